// File: design/pal_pkg.sv
// Shared types and constants for the positional array list unit.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

   localparam int PAL_DEPTH = 16;
   localparam int DATA_W    = 32;
   localparam int MODE_W    = 3;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LOCATE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   // what every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

endpackage

`default_nettype wire

// File: design/pal_cell.sv
// One storage cell of the list chain: holds one entry, shifts or rotates with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module pal_cell
   import pal_pkg::*;
#(
   parameter int DEPTH = PAL_DEPTH,
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  wire cell_op_type             op,
   input  wire [$clog2(DEPTH)-1:0]      pos,
   input  wire [DATA_W-1:0]             value,
   input  wire [DATA_W-1:0]             prev_data,
   input  wire [DATA_W-1:0]             next_data,
   output logic [DATA_W-1:0]            data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_INSERT: begin
            if (MY_IDX == pos) begin
               data_in = value;
            end else if (MY_IDX > pos) begin
               data_in = prev_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= pos) begin
               data_in = next_data;
            end
         end
         CELL_ROTATE: data_in = next_data;
         default:     data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// File: design/positional_array_list_unit.sv
// Top level of the positional array list unit: control and the chain of cells.
//
// Usage: items enter on the req_ channel (mode, position, value) and each
// gives exactly one item on the rsp_ channel (ok, read_value,
// found_position, count). Both channels are valid/ready handshakes.
// The list lives in a chain of DEPTH cells. Insert shifts the cells above
// the position up, so insert, clear, unknown modes and any rejected
// position answer in the cycle after acceptance. Get and locate rotate
// the whole chain once past cell 0, one cell per cycle, and answer when
// the rotation ends; delete answers only after the shift down that
// follows the rotation.
// One item is in work at a time: req_ready is high only while no item is
// in work and the result register is empty or being taken that cycle.
// When the receiver stalls, the result holds on rsp_ and no new item is
// accepted. Reset empties the list (length zero) and drops any pending
// result; cell contents are not cleared and need not be.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list_unit
   import pal_pkg::*;
#(
   parameter int DEPTH = PAL_DEPTH
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [MODE_W-1:0]                   req_mode,
   input  wire [$clog2(DEPTH+2)-1:0]          req_position,
   input  wire signed [DATA_W-1:0]            req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_ok,
   output logic signed [DATA_W-1:0]           rsp_read_value,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_found_position,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = $clog2(DEPTH + 2);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELETE
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    len_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    pos_ff;
   logic [MODE_W-1:0]   mode_ff;
   logic [DATA_W-1:0]   key_ff;
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [DATA_W-1:0]   rsp_read_value_ff;
   logic [CNT_W-1:0]    rsp_found_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic                accept;
   logic [POS_W-1:0]    len_pos;
   logic                ins_ok;
   logic                rd_ok;
   logic [IDX_W-1:0]    req_pos0;
   cell_op_type         cell_op;
   logic [IDX_W-1:0]    cell_pos;
   logic [DATA_W-1:0]   cell_data [DEPTH];

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign len_pos  = POS_W'(len_ff);
   assign ins_ok   = (req_position != '0) && (req_position <= len_pos + POS_W'(1))
                     && (len_ff < FULL_CNT);
   assign rd_ok    = (req_position != '0) && (req_position <= len_pos);
   assign req_pos0 = IDX_W'(req_position - POS_W'(1));

   always_comb begin
      cell_op  = CELL_HOLD;
      cell_pos = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_INSERT && ins_ok) begin
               cell_op  = CELL_INSERT;
               cell_pos = req_pos0;
            end
         end
         ST_SCAN:   cell_op = CELL_ROTATE;
         ST_DELETE: cell_op = CELL_DELETE;
         default:   cell_op = CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      pal_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .pos       (cell_pos),
         .value     (req_value),
         .prev_data (cell_data[(i == 0) ? 0 : i - 1]),
         .next_data (cell_data[(i == DEPTH - 1) ? 0 : i + 1]),
         .data      (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  mode_ff           <= req_mode;
                  key_ff            <= req_value;
                  pos_ff            <= req_pos0;
                  scan_ff           <= '0;
                  rsp_read_value_ff <= '0;
                  rsp_found_ff      <= '0;
                  rsp_ok_ff         <= 1'b0;
                  rsp_count_ff      <= len_ff;
                  rsp_valid_ff      <= 1'b1;
                  case (req_mode)
                     MODE_INSERT: begin
                        if (ins_ok) begin
                           len_ff       <= len_ff + CNT_W'(1);
                           rsp_count_ff <= len_ff + CNT_W'(1);
                           rsp_ok_ff    <= 1'b1;
                        end
                     end
                     MODE_DELETE, MODE_GET: begin
                        if (rd_ok) begin
                           rsp_valid_ff <= 1'b0;
                           state_ff     <= ST_SCAN;
                        end
                     end
                     MODE_LOCATE: begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= ST_SCAN;
                     end
                     MODE_CLEAR: begin
                        len_ff       <= '0;
                        rsp_count_ff <= '0;
                        rsp_ok_ff    <= 1'b1;
                     end
                     default: rsp_ok_ff <= 1'b0;
                  endcase
               end
            end
            ST_SCAN: begin
               // cell 0 shows entry scan_ff this cycle
               if (mode_ff != MODE_LOCATE && scan_ff == pos_ff) begin
                  rsp_read_value_ff <= cell_data[0];
               end
               if (mode_ff == MODE_LOCATE && CNT_W'(scan_ff) < len_ff
                   && cell_data[0] == key_ff && rsp_found_ff == '0) begin
                  rsp_found_ff <= CNT_W'(scan_ff) + CNT_W'(1);
               end
               scan_ff <= scan_ff + IDX_W'(1);
               if (scan_ff == LAST_IDX) begin
                  if (mode_ff == MODE_DELETE) begin
                     state_ff <= ST_DELETE;
                  end else begin
                     rsp_ok_ff    <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            ST_DELETE: begin
               len_ff       <= len_ff - CNT_W'(1);
               rsp_count_ff <= len_ff - CNT_W'(1);
               rsp_ok_ff    <= 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_count          = rsp_count_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= FULL_CNT)
      else $error("list length above depth");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("item accepted while another is in work");

   a_scan_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending during scan");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_INSERT && ins_ok) |=>
         (len_ff == CNT_W'($past(len_ff) + CNT_W'(1))))
      else $error("accepted insert did not grow the list");

   a_delete_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELETE) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("delete shift did not finish the item");

endmodule

`default_nettype wire
